### hdl/dct_pkg.sv
// ============================================================================
// dct_pkg
// Shared types and constants for the detection confirm table.
// ============================================================================
`default_nettype none

package dct_pkg;

    localparam int COORD_W         = 16;
    localparam int HITS_W          = 16;
    localparam int TOTAL_W         = 16;
    localparam int WIN_W           = 13;
    localparam int THR_W           = 16;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_IDX_W       = 1;
    localparam int TABLE_DEPTH_DEF = 32;

    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(500);
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(4);

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIDE       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_THRESHOLD = CFG_IDX_W'(1);

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      point_valid;
        logic                      frame_end;
    } det_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic                      is_point;
        logic                      last;
        logic [TOTAL_W-1:0]        confirmed_total;
        logic                      table_overflow;
    } rpt_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [HITS_W-1:0]         hits;
        logic                      reported;
    } entry_t;

    typedef struct packed {
        logic accept;
        logic match_step;
        logic append;
        logic commit;
        logic rpt_read;
        logic rpt_check;
        logic close;
    } dp_cmd_t;

    typedef struct packed {
        logic has_point;
        logic frame_end;
        logic match_done;
        logic rpt_more;
        logic rpt_qual;
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

### hdl/dct_ram.sv
// ============================================================================
// dct_ram
// Generic single write port RAM with registered read.
// ============================================================================
`default_nettype none

module dct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/dct_ctrl.sv
// ============================================================================
// dct_ctrl
// Sequencer: match scan, append, commit, report scan, closing record.
// ============================================================================
`default_nettype none

module dct_ctrl
    import dct_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    det_valid,
    output logic         det_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_DISPATCH = 8'b0000_0010,
        ST_MATCH    = 8'b0000_0100,
        ST_APPEND   = 8'b0000_1000,
        ST_COMMIT   = 8'b0001_0000,
        ST_RREAD    = 8'b0010_0000,
        ST_RCHK     = 8'b0100_0000,
        ST_CLOSE    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        det_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                det_ready  = 1'b1;
                cmd.accept = det_valid;
                if (det_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (sts.has_point)
                begin
                    state_next = ST_MATCH;
                end
                else if (sts.frame_end)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MATCH:
            begin
                cmd.match_step = 1'b1;
                if (sts.match_done)
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = sts.frame_end ? ST_COMMIT : ST_IDLE;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_RREAD;
            end
            ST_RREAD:
            begin
                if (sts.rpt_more)
                begin
                    cmd.rpt_read = 1'b1;
                    state_next   = ST_RCHK;
                end
                else
                begin
                    state_next = ST_CLOSE;
                end
            end
            ST_RCHK:
            begin
                cmd.rpt_check = 1'b1;
                if (!sts.rpt_qual || sts.out_free)
                begin
                    state_next = ST_RREAD;
                end
            end
            ST_CLOSE:
            begin
                cmd.close = 1'b1;
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/dct_datapath.sv
// ============================================================================
// dct_datapath
// Entry table, window compare, counters, config and output register.
// ============================================================================
`default_nettype none

module dct_datapath
    import dct_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dp_cmd_t               cmd,
    output dp_sts_t                    sts,
    input  wire det_t                  det_data,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       rpt_valid,
    input  wire logic                  rpt_ready,
    output rpt_t                       rpt_data
);

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int DW    = COORD_W + 2;
    localparam int EW    = $bits(entry_t);

    // item and scan state
    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic                      pv_reg, fe_reg;
    logic [CNT_W-1:0]          rd_idx_reg;
    logic [AW-1:0]             chk_idx_reg;
    logic                      chk_vld_reg;
    logic                      hit_reg;
    logic [CNT_W-1:0]          entry_count_reg;
    logic [CNT_W-1:0]          committed_count_reg;
    logic [TOTAL_W-1:0]        total_reg;
    logic                      ovf_reg;
    logic [WIN_W-1:0]          win_reg;
    logic [THR_W-1:0]          thr_reg;
    logic                      out_valid_reg;
    rpt_t                      out_data_reg;

    logic                      ram_we, ram_re;
    logic [AW-1:0]             ram_waddr, ram_raddr;
    entry_t                    ram_wdata;
    logic [EW-1:0]             ram_rdata;
    entry_t                    rd_entry;

    logic signed [DW-1:0]      dx, dy, h_s;
    logic                      in_win;
    logic                      rd_more;
    logic                      room;
    logic                      qual;
    logic                      out_free;
    logic [HITS_W-1:0]         hits_inc;
    logic [TOTAL_W-1:0]        total_inc;
    logic                      emit_pt;
    logic                      emit_close;

    dct_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);

    assign h_s    = signed'(DW'(win_reg >> 1));
    assign dx     = DW'(px_reg) - DW'(rd_entry.x);
    assign dy     = DW'(py_reg) - DW'(rd_entry.y);
    assign in_win = (dx >= -h_s) && (dx < h_s) && (dy >= -h_s) && (dy < h_s);

    assign hits_inc  = (rd_entry.hits == '1) ? rd_entry.hits : rd_entry.hits + 1'b1;
    assign total_inc = (total_reg == '1) ? total_reg : total_reg + 1'b1;

    assign rd_more  = rd_idx_reg < committed_count_reg;
    assign room     = entry_count_reg < CNT_W'(TABLE_DEPTH);
    assign qual     = (rd_entry.hits >= thr_reg) && !rd_entry.reported;
    assign out_free = !out_valid_reg || rpt_ready;

    assign emit_pt    = cmd.rpt_check && qual && out_free;
    assign emit_close = cmd.close && out_free;

    assign sts.has_point  = pv_reg;
    assign sts.frame_end  = fe_reg;
    assign sts.match_done = !rd_more && !chk_vld_reg;
    assign sts.rpt_more   = rd_more;
    assign sts.rpt_qual   = qual;
    assign sts.out_free   = out_free;

    assign rpt_valid = out_valid_reg;
    assign rpt_data  = out_data_reg;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = chk_idx_reg;
        ram_wdata = rd_entry;
        ram_re    = 1'b0;
        ram_raddr = rd_idx_reg[AW-1:0];
        if (cmd.match_step)
        begin
            ram_re = rd_more;
            if (chk_vld_reg && in_win)
            begin
                ram_we         = 1'b1;
                ram_wdata.hits = hits_inc;
            end
        end
        if (cmd.append && !hit_reg && room)
        begin
            ram_we             = 1'b1;
            ram_waddr          = entry_count_reg[AW-1:0];
            ram_wdata.x        = px_reg;
            ram_wdata.y        = py_reg;
            ram_wdata.hits     = HITS_W'(1);
            ram_wdata.reported = 1'b0;
        end
        if (cmd.rpt_read)
        begin
            ram_re = 1'b1;
        end
        if (emit_pt)
        begin
            ram_we             = 1'b1;
            ram_waddr          = rd_idx_reg[AW-1:0];
            ram_wdata.reported = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg              <= 1'b0;
            fe_reg              <= 1'b0;
            rd_idx_reg          <= '0;
            chk_idx_reg         <= '0;
            chk_vld_reg         <= 1'b0;
            hit_reg             <= 1'b0;
            entry_count_reg     <= '0;
            committed_count_reg <= '0;
            total_reg           <= '0;
            ovf_reg             <= 1'b0;
            win_reg             <= WIN_RESET;
            thr_reg             <= THR_RESET;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_WINDOW_SIDE:       win_reg <= cfg_data[WIN_W-1:0];
                    CFG_CONFIRM_THRESHOLD: thr_reg <= cfg_data[THR_W-1:0];
                    default:               ;
                endcase
            end

            if (cmd.accept)
            begin
                pv_reg      <= det_data.point_valid;
                fe_reg      <= det_data.frame_end;
                rd_idx_reg  <= '0;
                chk_vld_reg <= 1'b0;
                hit_reg     <= 1'b0;
            end

            if (cmd.match_step)
            begin
                chk_vld_reg <= rd_more;
                chk_idx_reg <= rd_idx_reg[AW-1:0];
                if (rd_more)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
                if (chk_vld_reg && in_win)
                begin
                    hit_reg <= 1'b1;
                end
            end

            if (cmd.append && !hit_reg)
            begin
                if (room)
                begin
                    entry_count_reg <= entry_count_reg + 1'b1;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end

            if (cmd.commit)
            begin
                committed_count_reg <= entry_count_reg;
                rd_idx_reg          <= '0;
            end

            if (cmd.rpt_check && (!qual || out_free))
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end

            if (emit_pt)
            begin
                total_reg <= total_inc;
            end

            if (emit_pt || emit_close)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rpt_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            px_reg <= det_data.point_x;
            py_reg <= det_data.point_y;
        end
        if (emit_pt)
        begin
            out_data_reg.out_x           <= rd_entry.x;
            out_data_reg.out_y           <= rd_entry.y;
            out_data_reg.is_point        <= 1'b1;
            out_data_reg.last            <= 1'b0;
            out_data_reg.confirmed_total <= total_inc;
            out_data_reg.table_overflow  <= ovf_reg;
        end
        else if (emit_close)
        begin
            out_data_reg.out_x           <= '0;
            out_data_reg.out_y           <= '0;
            out_data_reg.is_point        <= 1'b0;
            out_data_reg.last            <= 1'b1;
            out_data_reg.confirmed_total <= total_reg;
            out_data_reg.table_overflow  <= ovf_reg;
        end
    end

endmodule

`default_nettype wire

### hdl/detection_confirm_table.sv
// ============================================================================
// detection_confirm_table
// Confirms detected points that recur across frames and reports them.
// ============================================================================
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------
//  det     | det_valid/det_ready   | det_data  (dct_pkg::det_t)
//  rpt     | rpt_valid/rpt_ready   | rpt_data  (dct_pkg::rpt_t)
//  cfg     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
//  An item is accepted and dispatched; with a point, the committed entries
//  are read one per cycle through the single RAM read port and matched.
//  A frame end adds commit, a report scan that reads and checks each
//  committed entry, scan end and the closing record.
//  Output stalls hold the report scan and the closing record.
//  After reset the table is empty; cfg writes are taken every cycle.
// ============================================================================
`default_nettype none

module detection_confirm_table
    import dct_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  det_valid,
    output logic                       det_ready,
    input  wire det_t                  det_data,
    output logic                       rpt_valid,
    input  wire logic                  rpt_ready,
    output rpt_t                       rpt_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    dct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .det_valid (det_valid),
        .det_ready (det_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    dct_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .det_data  (det_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rpt_valid (rpt_valid),
        .rpt_ready (rpt_ready),
        .rpt_data  (rpt_data)
    );

endmodule

`default_nettype wire

### verif/detection_confirm_table_tb.sv
// ============================================================================
// detection_confirm_table_tb
// Self-checking bench for the detection confirm table. A directed table of
// transactions walks the boundary cases (empty frames, window edges, deferred
// entries, tiny window, threshold zero, register extremes), then randomized
// frames aim most points at committed entries so hits build up and entries
// get confirmed, with a share of scattered points to fill the table until it
// overflows. Every report is checked field by field against a local tracker
// model; both channels stall in random bursts except in the final phase.
// ============================================================================
module detection_confirm_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dct_pkg::*;

    localparam int DEPTH      = TABLE_DEPTH_DEF;
    localparam int DRAIN      = 150;
    localparam int STALL_MAX  = 2000;
    localparam int TAIL       = 200;

    typedef enum logic {ROW_POINT, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [CFG_DATA_W-1:0]   reg_val;
        det_t                    det;
        logic                    typed;
        rpt_t                    want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  det_valid = 1'b0;
    logic                  det_ready;
    det_t                  det_data = '0;
    logic                  rpt_valid;
    logic                  rpt_ready = 1'b0;
    rpt_t                  rpt_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // tracker model state
    logic signed [COORD_W-1:0] trk_x [DEPTH];
    logic signed [COORD_W-1:0] trk_y [DEPTH];
    logic [HITS_W-1:0]         trk_hits [DEPTH];
    logic                      trk_reported [DEPTH];
    int unsigned               trk_count = 0;
    int unsigned               trk_committed = 0;
    logic [TOTAL_W-1:0]        trk_confirmed = '0;
    logic                      trk_overflow = 1'b0;
    logic [WIN_W-1:0]          win_side = WIN_RESET;
    logic [THR_W-1:0]          confirm_thr = THR_RESET;

    rpt_t pending_reports [$];

    int  errors = 0;
    int  reports_seen = 0;
    int  points_sent = 0;
    int  stall_count = 0;
    int  ready_hold = 0;
    bit  calm = 1'b0;

    detection_confirm_table #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .det_valid (det_valid),
        .det_ready (det_ready),
        .det_data  (det_data),
        .rpt_valid (rpt_valid),
        .rpt_ready (rpt_ready),
        .rpt_data  (rpt_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic rpt_t closing_rpt(input logic [TOTAL_W-1:0] total, input logic ovf);
        rpt_t r;
        r = '0;
        r.last = 1'b1;
        r.confirmed_total = total;
        r.table_overflow = ovf;
        return r;
    endfunction

    function automatic stim_row_t point_row(input int x, input int y, input bit v, input bit e);
        stim_row_t r;
        r = '0;
        r.kind = ROW_POINT;
        r.det.point_x = COORD_W'(x);
        r.det.point_y = COORD_W'(y);
        r.det.point_valid = v;
        r.det.frame_end = e;
        return r;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r = '0;
        r.kind = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic bit in_window(input int c, input int p, input int h);
        return (c - h <= p) && (p < c + h);
    endfunction

    // Advances the tracker by one transaction and, when publish is set, queues the reports it causes.
    task automatic advance_tracks(input det_t d, input bit publish);
        int   h;
        int   px;
        int   py;
        bit   hit;
        rpt_t r;
        h = int'(win_side >> 1);
        if (d.point_valid)
        begin
            px = $signed(d.point_x);
            py = $signed(d.point_y);
            hit = 1'b0;
            for (int i = 0; i < int'(trk_committed); i++)
            begin
                if (in_window($signed(trk_x[i]), px, h) && in_window($signed(trk_y[i]), py, h))
                begin
                    hit = 1'b1;
                    if (trk_hits[i] != '1)
                        trk_hits[i] = trk_hits[i] + 1'b1;
                end
            end
            if (!hit)
            begin
                if (trk_count < DEPTH)
                begin
                    trk_x[trk_count] = d.point_x;
                    trk_y[trk_count] = d.point_y;
                    trk_hits[trk_count] = HITS_W'(1);
                    trk_reported[trk_count] = 1'b0;
                    trk_count++;
                end
                else
                begin
                    trk_overflow = 1'b1;
                end
            end
        end
        if (d.frame_end)
        begin
            trk_committed = trk_count;
            for (int i = 0; i < int'(trk_committed); i++)
            begin
                if (trk_hits[i] >= confirm_thr && !trk_reported[i])
                begin
                    trk_reported[i] = 1'b1;
                    if (trk_confirmed != '1)
                        trk_confirmed = trk_confirmed + 1'b1;
                    r = '0;
                    r.out_x = trk_x[i];
                    r.out_y = trk_y[i];
                    r.is_point = 1'b1;
                    r.confirmed_total = trk_confirmed;
                    r.table_overflow = trk_overflow;
                    if (publish)
                        pending_reports.insert(pending_reports.size(), r);
                end
            end
            if (publish)
                pending_reports.insert(pending_reports.size(),
                                       closing_rpt(trk_confirmed, trk_overflow));
        end
    endtask

    task automatic sender_pause(input int n);
        @(negedge clk);
        det_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic maybe_pause();
        if (!calm && $urandom_range(0, 3) == 0)
            sender_pause($urandom_range(1, 19));
    endtask

    task automatic send_det(input det_t d, input bit typed, input rpt_t want);
        @(negedge clk);
        det_valid <= 1'b1;
        det_data <= d;
        @(posedge clk);
        while (!det_ready)
            @(posedge clk);
        advance_tracks(d, !typed);
        if (typed)
            pending_reports.insert(pending_reports.size(), want);
        if (d.point_valid || d.frame_end)
            points_sent++;
    endtask

    // Registers change only once the block has drained.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        det_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_WINDOW_SIDE)
            win_side = WIN_W'(val);
        else if (idx == CFG_CONFIRM_THRESHOLD)
            confirm_thr = THR_W'(val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_frames(input logic [CFG_DATA_W-1:0] win,
                                 input logic [CFG_DATA_W-1:0] thr, input int quota);
        int   sent;
        int   len;
        int   k;
        int   h;
        det_t d;
        write_reg(CFG_WINDOW_SIDE, win);
        write_reg(CFG_CONFIRM_THRESHOLD, thr);
        sent = 0;
        while (sent < quota)
        begin
            len = $urandom_range(1, 5);
            for (int j = 0; j < len; j++)
            begin
                d = '0;
                d.point_valid = ($urandom_range(0, 9) != 0);
                d.frame_end = (j == len - 1);
                if (trk_committed != 0 && $urandom_range(0, 9) < 6)
                begin
                    // aim at a committed entry, sometimes just past its window edge
                    k = $urandom_range(0, trk_committed - 1);
                    h = int'(win_side >> 1);
                    d.point_x = COORD_W'($signed(trk_x[k]) + int'($urandom_range(0, 2 * h + 1)) - h - 1);
                    d.point_y = COORD_W'($signed(trk_y[k]) + int'($urandom_range(0, 2 * h + 1)) - h - 1);
                end
                else
                begin
                    d.point_x = COORD_W'($urandom);
                    d.point_y = COORD_W'($urandom);
                end
                maybe_pause();
                send_det(d, 1'b0, '0);
                if (d.point_valid || d.frame_end)
                    sent++;
                if ($urandom_range(0, 9) == 0)
                begin
                    d = '0;
                    d.point_x = COORD_W'($urandom);
                    d.point_y = COORD_W'($urandom);
                    send_det(d, 1'b0, '0);
                end
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            rpt_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 99) < 15)
        begin
            ready_hold <= $urandom_range(0, 18);
            rpt_ready <= 1'b0;
        end
        else
        begin
            rpt_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        rpt_t want;
        if (rst_n && rpt_valid && rpt_ready)
        begin
            reports_seen++;
            if (pending_reports.size() == 0)
            begin
                $error("unexpected report transaction: %h", rpt_data);
                errors++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("out_x", 32'(want.out_x), 32'(rpt_data.out_x));
                check_field("out_y", 32'(want.out_y), 32'(rpt_data.out_y));
                check_field("is_point", 32'(want.is_point), 32'(rpt_data.is_point));
                check_field("last", 32'(want.last), 32'(rpt_data.last));
                check_field("confirmed_total", 32'(want.confirmed_total),
                            32'(rpt_data.confirmed_total));
                check_field("table_overflow", 32'(want.table_overflow),
                            32'(rpt_data.table_overflow));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((det_valid && det_ready) || (rpt_valid && rpt_ready) || (cfg_valid && cfg_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_MAX)
        begin
            $display("detection_confirm_table_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        stim_row_t directed [$];
        stim_row_t r;

        r = point_row(0, 0, 0, 1);
        r.typed = 1'b1;
        r.want = closing_rpt('0, 1'b0);
        directed.insert(directed.size(), r);
        directed.insert(directed.size(), point_row(-1, 16'h5A5A, 0, 0));
        directed.insert(directed.size(), point_row(32767, -32768, 1, 0));
        directed.insert(directed.size(), point_row(-32768, 32767, 1, 0));
        r = point_row(0, 0, 1, 1);
        r.typed = 1'b1;
        r.want = closing_rpt('0, 1'b0);
        directed.insert(directed.size(), r);
        directed.insert(directed.size(), reg_row(CFG_CONFIRM_THRESHOLD, 16'd1));
        directed.insert(directed.size(), point_row(0, 0, 0, 1));
        // window edges: low bound inclusive, high bound exclusive
        directed.insert(directed.size(), point_row(32517, -32519, 1, 0));
        directed.insert(directed.size(), point_row(249, -250, 1, 0));
        directed.insert(directed.size(), point_row(250, 0, 1, 0));
        // new entries stay out of matching until the frame closes
        directed.insert(directed.size(), point_row(250, 0, 1, 0));
        directed.insert(directed.size(), point_row(0, 0, 0, 1));
        directed.insert(directed.size(), reg_row(CFG_WINDOW_SIDE, 16'd1));
        directed.insert(directed.size(), point_row(0, 0, 1, 1));
        directed.insert(directed.size(), reg_row(CFG_WINDOW_SIDE, 16'hF000));
        directed.insert(directed.size(), reg_row(CFG_CONFIRM_THRESHOLD, 16'd0));
        directed.insert(directed.size(), point_row(-20000, 20000, 1, 0));
        directed.insert(directed.size(), point_row(100, 100, 1, 1));
        directed.insert(directed.size(), reg_row(CFG_WINDOW_SIDE, 16'd2));
        directed.insert(directed.size(), reg_row(CFG_CONFIRM_THRESHOLD, 16'hFFFF));
        directed.insert(directed.size(), point_row(1, -1, 1, 1));
        directed.insert(directed.size(), point_row(-32768, -32768, 1, 1));
        directed.insert(directed.size(), reg_row(CFG_WINDOW_SIDE, 16'd4096));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_REG)
            begin
                write_reg(directed[i].reg_idx, directed[i].reg_val);
            end
            else
            begin
                maybe_pause();
                send_det(directed[i].det, directed[i].typed, directed[i].want);
            end
        end

        random_frames(16'd500, 16'd3, 20);
        random_frames(CFG_DATA_W'($urandom_range(2, 4096)), CFG_DATA_W'($urandom_range(1, 8)), 20);
        random_frames(16'd4096, 16'd2, 20);
        calm = 1'b1;
        random_frames(CFG_DATA_W'($urandom_range(2, 600)), 16'd1, 20);

        @(negedge clk);
        det_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);

        $display("detection_confirm_table_tb: %0d point/frame transactions, %0d reports checked",
                 points_sent, reports_seen);
        $display("detection_confirm_table_tb: %0d entries tracked, %0d confirmed, overflow %0b",
                 trk_count, trk_confirmed, trk_overflow);
        if (errors == 0)
            $display("detection_confirm_table_tb: done, clean");
        else
            $display("detection_confirm_table_tb: done, errors");
        $finish;
    end

endmodule
